/* hdl/ndts_pkg.sv */
// Shared types and constants for the deadline tick scheduler.
// No dependencies.
package ndts_pkg;
  localparam int MaxTasks   = 8;
  localparam int QueueDepth = 16;
  localparam int TaskW      = 3;
  localparam int QIdxW      = 4;
  localparam int QCntW      = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic KIND_MISS = 1'b0;
  localparam logic KIND_SLOT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [2:0]  task_index;
    logic [15:0] period;
    logic [15:0] run_ticks;
    logic [15:0] release_offset;
    logic [15:0] rel_deadline;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  which_task;
    logic [15:0] job_number;
    logic        idle;
    logic [31:0] tick_time;
    logic        overflow;
    logic        last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // write task entry from input word
    logic rel_start;  // clear release index and drop flag
    logic rel_step;   // evaluate release of task rel_idx, advance
    logic sel_start;  // begin selection scan
    logic sel_step;   // compare one queue entry, advance
    logic exec;       // start pick (if any), emit slot, advance time
    logic rm_start;   // begin removal search
    logic rm_step;    // one removal step
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rel_done;
    logic rel_emit;   // current release step produces a miss word
    logic sel_done;
    logic rm_needed;
    logic rm_done;
  } stat_t;
endpackage

/* hdl/ndts_if.sv */
// Valid/ready channel interfaces for input and result words.
// Depends on ndts_pkg.
interface ndts_in_if;
  logic valid;
  logic ready;
  ndts_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ndts_out_if;
  logic valid;
  logic ready;
  ndts_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/ndts_datapath.sv */
// Task table, pending queue, scan counters and timekeeping.
// Depends on ndts_pkg.
module ndts_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ndts_pkg::cmd_t     cmd,
  input  ndts_pkg::in_word_t in_word,
  input  logic [3:0]         active_tasks,
  output ndts_pkg::stat_t    stat,
  output ndts_pkg::out_word_t miss_word,
  output ndts_pkg::out_word_t slot_word
);
  import ndts_pkg::*;

  logic [15:0] task_period [MaxTasks];
  logic [15:0] task_run_ticks [MaxTasks];
  logic [15:0] task_deadline [MaxTasks];
  logic [31:0] next_release [MaxTasks];
  logic [15:0] jobs_started [MaxTasks];
  logic [TaskW-1:0] pending_jobs [QueueDepth];
  logic [QCntW-1:0] pending_count;
  logic [31:0] now;
  logic busy;
  logic [TaskW-1:0] current_task;
  logic [15:0] ticks_executed;

  logic [3:0] rel_idx;       // holds MaxTasks
  logic dropped_any;
  logic [QCntW-1:0] scan;    // holds QueueDepth
  logic [TaskW-1:0] pick;
  logic [QCntW-1:0] rm_pos;
  logic rm_found;

  logic [3:0] n_act;
  logic [TaskW-1:0] rt;
  logic released, in_q, full, sel_ok;
  logic [TaskW-1:0] scan_task;

  assign n_act = (active_tasks > 4'(MaxTasks)) ? 4'(MaxTasks) : active_tasks;
  assign rt = rel_idx[TaskW-1:0];
  assign released = (rel_idx < n_act) && (now >= next_release[rt]);
  assign full = (pending_count == QCntW'(QueueDepth));
  assign scan_task = pending_jobs[scan[QIdxW-1:0]];

  // membership test over the queue: independent compares
  always_comb begin
    in_q = 1'b0;
    for (int i = 0; i < QueueDepth; i++)
      if (QCntW'(i) < pending_count && pending_jobs[i] == rt) in_q = 1'b1;
  end

  assign sel_ok = !busy && pending_count != '0;

  assign stat.rel_done = (rel_idx >= n_act);
  assign stat.rel_emit = released && in_q;
  assign stat.sel_done = (scan >= pending_count);
  assign stat.rm_needed = busy &&
      (ticks_executed + 16'd1 >= task_run_ticks[current_task]);
  // removal ends on the last shift step, or when the search runs off the end
  assign stat.rm_done = rm_found ? !(rm_pos + 1'b1 < pending_count)
                                 : (rm_pos >= pending_count);

  always_comb begin
    miss_word.kind = KIND_MISS;
    miss_word.which_task = rt;
    miss_word.job_number = jobs_started[rt];
    miss_word.idle = 1'b0;
    miss_word.tick_time = now;
    miss_word.overflow = full;
    miss_word.last = 1'b0;
  end

  logic [TaskW-1:0] run_id;
  logic run_busy;
  assign run_busy = busy || sel_ok;
  assign run_id = busy ? current_task : pick;

  always_comb begin
    slot_word.kind = KIND_SLOT;
    slot_word.which_task = run_busy ? run_id : '0;
    slot_word.job_number = run_busy ? jobs_started[run_id] + (busy ? 16'd0 : 16'd1)
                                    : 16'd0;
    slot_word.idle = !run_busy;
    slot_word.tick_time = now;
    slot_word.overflow = dropped_any;
    slot_word.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      task_period[in_word.task_index] <= in_word.period;
      task_run_ticks[in_word.task_index] <= in_word.run_ticks;
      task_deadline[in_word.task_index] <= in_word.rel_deadline;
    end
    if (cmd.rel_step && released && !full)
      pending_jobs[pending_count[QIdxW-1:0]] <= rt;
    if (cmd.rm_step && !rm_found && rm_pos < pending_count) begin
      if (pending_jobs[rm_pos[QIdxW-1:0]] == current_task) rm_found <= 1'b1;
      else rm_pos <= rm_pos + 1'b1;
    end
    if (cmd.rm_step && rm_found) begin
      // shift one entry down per step, then shrink
      if (rm_pos + 1'b1 < pending_count) begin
        pending_jobs[rm_pos[QIdxW-1:0]] <= pending_jobs[rm_pos[QIdxW-1:0] + 1'b1];
        rm_pos <= rm_pos + 1'b1;
      end
    end
    if (cmd.rm_start) begin
      rm_pos <= '0;
      rm_found <= 1'b0;
    end
    if (cmd.sel_start) begin
      pick <= pending_jobs[0];
      scan <= QCntW'(1);
    end
    if (cmd.sel_step) begin
      if (task_deadline[scan_task] < task_deadline[pick]) pick <= scan_task;
      scan <= scan + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
      pending_count <= '0;
      busy <= 1'b0;
      current_task <= '0;
      ticks_executed <= '0;
      rel_idx <= '0;
      dropped_any <= 1'b0;
      for (int i = 0; i < MaxTasks; i++) begin
        jobs_started[i] <= '0;
        next_release[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        next_release[in_word.task_index] <= {16'd0, in_word.release_offset};
        jobs_started[in_word.task_index] <= '0;
      end
      if (cmd.rel_start) begin
        rel_idx <= '0;
        dropped_any <= 1'b0;
      end
      if (cmd.rel_step) begin
        if (released) begin
          if (full) dropped_any <= 1'b1;
          else pending_count <= pending_count + 1'b1;
          next_release[rt] <= next_release[rt] + {16'd0, task_period[rt]};
        end
        rel_idx <= rel_idx + 1'b1;
      end
      if (cmd.exec) begin
        now <= now + 32'd1;
        if (!busy && sel_ok) begin
          jobs_started[pick] <= jobs_started[pick] + 16'd1;
          current_task <= pick;
          busy <= 1'b1;
          ticks_executed <= '0;
        end else if (busy) begin
          ticks_executed <= ticks_executed + 16'd1;
        end
      end
      // removal finishes: drop the entry, free the runner
      if (cmd.rm_step && stat.rm_done) begin
        if (rm_found) pending_count <= pending_count - 1'b1;
        busy <= 1'b0;
        ticks_executed <= '0;
      end
    end
  end
endmodule

/* hdl/ndts_ctrl.sv */
// Sequencer for one input word: release scan, selection, slot, removal.
// Depends on ndts_pkg.
module ndts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_slot,
  input  ndts_pkg::stat_t     stat,
  output ndts_pkg::cmd_t      cmd
);
  import ndts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_REL  = 7'b0000010,
    S_MISS = 7'b0000100,
    S_SEL  = 7'b0001000,
    S_SLOT = 7'b0010000,
    S_RMS  = 7'b0100000,
    S_RM   = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_MISS) || (state == S_SLOT);
  assign out_slot = (state == S_SLOT);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOAD) cmd.load = 1'b1;
          else begin
            cmd.rel_start = 1'b1;
            state_next = S_REL;
          end
        end
      end
      S_REL: begin
        if (stat.rel_done) begin
          cmd.sel_start = 1'b1;
          state_next = S_SEL;
        end else if (stat.rel_emit) state_next = S_MISS;
        else cmd.rel_step = 1'b1;
      end
      S_MISS: begin
        // hold the miss word until taken, then commit the release
        if (out_ready) begin
          cmd.rel_step = 1'b1;
          state_next = S_REL;
        end
      end
      S_SEL: begin
        if (stat.sel_done) state_next = S_SLOT;
        else cmd.sel_step = 1'b1;
      end
      S_SLOT: begin
        if (out_ready) begin
          cmd.exec = 1'b1;
          state_next = S_RMS;
        end
      end
      S_RMS: begin
        if (stat.rm_needed) begin
          cmd.rm_start = 1'b1;
          state_next = S_RM;
        end else state_next = S_IDLE;
      end
      S_RM: begin
        cmd.rm_step = 1'b1;
        if (stat.rm_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* hdl/nonpreemptive_deadline_tick_scheduler.sv */
// Nonpreemptive deadline-monotonic tick scheduler, top level.
// Depends on ndts_pkg, ndts_if, ndts_ctrl, ndts_datapath.
// A load word is taken straight from idle. A tick word walks the task table
// one entry a cycle, pausing at each miss word until it is taken at the
// output, scans the pending queue one entry a cycle for the shortest
// deadline, emits the slot word, and when a job finishes searches the queue
// for it and shifts it out. Result words are presented straight from the
// scheduler state and hold until taken.
module nonpreemptive_deadline_tick_scheduler (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic [3:0] cfg_wdata,
  ndts_in_if.sink   in_ch,
  ndts_out_if.source out_ch
);
  import ndts_pkg::*;

  logic [3:0] active_tasks;
  cmd_t cmd;
  stat_t stat;
  out_word_t miss_word, slot_word;
  logic out_slot;

  always_ff @(posedge clk) begin
    if (rst) active_tasks <= '0;
    else if (cfg_we) active_tasks <= cfg_wdata;
  end

  ndts_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_op(in_ch.data.op), .in_ready(in_ch.ready),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_slot(out_slot),
    .stat(stat), .cmd(cmd)
  );

  ndts_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(in_ch.data),
    .active_tasks(active_tasks), .stat(stat),
    .miss_word(miss_word), .slot_word(slot_word)
  );

  assign out_ch.data = out_slot ? slot_word : miss_word;
endmodule

/* tb/tb_nonpreemptive_deadline_tick_scheduler.sv */
// Testbench for the deadline tick scheduler: random load and tick words,
// a scoreboard with its own scheduler model. Depends on ndts_pkg, ndts_if.
`timescale 1ns / 100ps

class sched_scoreboard;
  bit [3:0] active_cnt;
  bit [31:0] now_t;
  bit [15:0] per_tab[8];
  bit [15:0] run_tab[8];
  bit [15:0] dl_tab[8];
  bit [31:0] next_rel[8];
  bit [15:0] jobs_cnt[8];
  bit [2:0] ready_q[$];
  bit busy;
  bit [2:0] cur;
  bit [15:0] ran;
  ndts_pkg::out_word_t pending_words[$];
  int errors;

  function void clear();
    active_cnt = 0; now_t = 0; busy = 0; cur = 0; ran = 0;
    ready_q.delete(); pending_words.delete(); errors = 0;
    for (int i = 0; i < 8; i++) begin
      next_rel[i] = 0; jobs_cnt[i] = 0;
    end
  endfunction

  function void emit(bit kind, bit [2:0] t, bit [15:0] j, bit idl, bit ovf, bit lst);
    ndts_pkg::out_word_t w;
    w.kind = kind; w.which_task = t; w.job_number = j; w.idle = idl;
    w.tick_time = now_t; w.overflow = ovf; w.last = lst;
    pending_words = {pending_words, w};
  endfunction

  function void note_input(ndts_pkg::in_word_t w);
    int n;
    bit any_drop, miss, drop;
    bit [2:0] pick;
    if (w.op == ndts_pkg::OP_LOAD) begin
      per_tab[w.task_index] = w.period;
      run_tab[w.task_index] = w.run_ticks;
      next_rel[w.task_index] = {16'd0, w.release_offset};
      dl_tab[w.task_index] = w.rel_deadline;
      jobs_cnt[w.task_index] = 0;
      return;
    end
    n = active_cnt > 8 ? 8 : active_cnt;
    any_drop = 0;
    for (int i = 0; i < n; i++) begin
      if (now_t >= next_rel[i]) begin
        miss = 0;
        foreach (ready_q[k]) if (ready_q[k] == i) miss = 1;
        drop = ready_q.size() >= 16;
        if (drop) any_drop = 1; else ready_q = {ready_q, i[2:0]};
        if (miss) emit(ndts_pkg::KIND_MISS, i[2:0], jobs_cnt[i], 0, drop, 0);
        next_rel[i] = next_rel[i] + per_tab[i];
      end
    end
    if (!busy && ready_q.size() > 0) begin
      pick = ready_q[0];
      for (int k = 1; k < ready_q.size(); k++)
        if (dl_tab[ready_q[k]] < dl_tab[pick]) pick = ready_q[k];
      busy = 1; cur = pick; jobs_cnt[pick]++; ran = 0;
    end
    if (busy) begin
      emit(ndts_pkg::KIND_SLOT, cur, jobs_cnt[cur], 0, any_drop, 1);
      if (32'(ran) + 1 >= 32'(run_tab[cur])) begin
        for (int k = 0; k < ready_q.size(); k++)
          if (ready_q[k] == cur) begin
            ready_q.delete(k);
            break;
          end
        busy = 0; ran = 0;
      end else begin
        ran++;
      end
    end else begin
      emit(ndts_pkg::KIND_SLOT, 0, 0, 1, any_drop, 1);
    end
    now_t++;
  endfunction

  function void check_result(ndts_pkg::out_word_t got);
    ndts_pkg::out_word_t exp_w;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
      return;
    end
    exp_w = pending_words.pop_front();
    if (got.kind != exp_w.kind)
      $display("%0t: kind exp %0d got %0d", $time, exp_w.kind, got.kind);
    if (got.which_task != exp_w.which_task)
      $display("%0t: which_task exp %0d got %0d", $time, exp_w.which_task, got.which_task);
    if (got.job_number != exp_w.job_number)
      $display("%0t: job_number exp %0d got %0d", $time, exp_w.job_number, got.job_number);
    if (got.idle != exp_w.idle)
      $display("%0t: idle exp %0d got %0d", $time, exp_w.idle, got.idle);
    if (got.tick_time != exp_w.tick_time)
      $display("%0t: tick_time exp %0d got %0d", $time, exp_w.tick_time, got.tick_time);
    if (got.overflow != exp_w.overflow)
      $display("%0t: overflow exp %0d got %0d", $time, exp_w.overflow, got.overflow);
    if (got.last != exp_w.last)
      $display("%0t: last exp %0d got %0d", $time, exp_w.last, got.last);
    if (got != exp_w) errors++;
  endfunction
endclass

module tb_nonpreemptive_deadline_tick_scheduler;
  import ndts_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_wdata;
  ndts_in_if in_ch ();
  ndts_out_if out_ch ();

  nonpreemptive_deadline_tick_scheduler dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  sched_scoreboard sb;
  bit [7:0] loaded;
  int hold_cycles;
  int idle_cycles;
  bit timed_out;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus long hold-offs when asked.
  initial begin
    out_ch.ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      out_ch.ready <= ($urandom_range(0, 3) != 0) || (gap_len() == 0);
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  // Watchdog over cycles without any accepted word.
  initial begin
    idle_cycles = 0;
    timed_out = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("tb_nonpreemptive_deadline_tick_scheduler NOT OK");
        $finish;
      end
    end
  end

  // Valid stays up between back-to-back words; a gap or drain drops it.
  task automatic send_word(in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.data <= w;
    in_ch.valid <= 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(w);
  endtask

  task automatic load_task(bit [2:0] idx, bit [15:0] per, bit [15:0] run,
                           bit [15:0] off, bit [15:0] dl);
    in_word_t w;
    w.op = OP_LOAD; w.task_index = idx; w.period = per; w.run_ticks = run;
    w.release_offset = off; w.rel_deadline = dl;
    loaded[idx] = 1;
    send_word(w);
  endtask

  task automatic tick(bit noise = 0);
    in_word_t w;
    w = '{op: OP_TICK, default: '0};
    if (noise) begin
      w.task_index = 3'($urandom);
      w.period = 16'($urandom);
      w.run_ticks = 16'($urandom);
      w.release_offset = 16'($urandom);
      w.rel_deadline = 16'($urandom);
    end
    send_word(w);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending_words.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Only allow active counts that cover loaded entries.
  task automatic set_active(bit [3:0] v);
    cfg_wdata <= v;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    sb.active_cnt = v;
  endtask

  function automatic int max_active();
    int m;
    m = 0;
    while (m < 8 && loaded[m]) m++;
    return m;
  endfunction

  task automatic random_load();
    bit [15:0] per, run;
    int r;
    r = $urandom_range(0, 9);
    per = r == 0 ? 16'($urandom) : 16'($urandom_range(0, 12));
    run = r == 1 ? 16'($urandom) : 16'($urandom_range(0, 4));
    load_task(3'($urandom_range(0, 7)), per, run,
              r == 2 ? 16'($urandom) : 16'($urandom_range(0, 10)), 16'($urandom));
  endtask

  initial begin
    int act;
    sb = new();
    sb.clear();
    loaded = 0;
    hold_cycles = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: idle ticks with no tasks, extremes of the fields.
    tick(); tick(1);
    load_task(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_task(1, 0, 0, 0, 0);
    load_task(2, 1, 1, 0, 0);
    load_task(3, 3, 2, 1, 16'h0005);
    load_task(4, 2, 3, 0, 16'h0005);
    load_task(5, 0, 1, 0, 16'h8000);
    load_task(6, 5, 1, 2, 16'h7FFF);
    load_task(7, 0, 2, 0, 16'h0001);
    drain();
    set_active(4'd15);
    // Period-zero tasks flood the queue: misses and overflow.
    repeat (12) tick();
    drain();
    set_active(4'd3);
    repeat (4) tick();
    drain();
    set_active(4'd0);
    tick();
    drain();
    set_active(4'd8);

    // Long receiver hold-off while ticks keep coming.
    hold_cycles = 400;
    repeat (6) tick();
    drain();

    // Random phases.
    for (int ph = 0; ph < 10; ph++) begin
      act = max_active();
      set_active(ph == 0 ? 4'd8 : ph == 1 ? 4'd9 : 4'($urandom_range(0, act)));
      for (int i = 0; i < 28; i++) begin
        if ($urandom_range(0, 6) == 0) random_load();
        else tick(1'($urandom_range(0, 1)));
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("tb_nonpreemptive_deadline_tick_scheduler OK");
    else
      $display("tb_nonpreemptive_deadline_tick_scheduler NOT OK");
    $finish;
  end
endmodule
